// File: hdl/crchk_pkg.sv
// Package for the chunked receive checker: item codes, status codes, FSM states,
// controller/datapath command and status structs.
// Has no dependencies; the ctrl, dp and top-level files all use it.
package crchk_pkg;

    localparam int OFFSET_BITS_DEF = 32;

    // Field widths fixed by the item format
    localparam int FIELD_W = 32;
    localparam int BYTE_W  = 8;
    localparam int PROG_W  = 7;

    // Progress divider: dividend is offset*100 (at most 39 bits); the quotient is
    // kept to 8 bits, and a larger quotient is caught up front as saturation.
    localparam int QUO_W   = 8;
    localparam int DIV_W   = FIELD_W + QUO_W;
    localparam int IDX_W   = 3;

    localparam logic [FIELD_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [FIELD_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [PROG_W-1:0]  PERCENT_FULL = 7'd100;

    // Action codes of an input beat
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_DATA  = 2'd1;
    localparam logic [1:0] ACT_END   = 2'd2;

    typedef enum logic [1:0] {
        ST_STARTED  = 2'd0,
        ST_TRANSFER = 2'd1,
        ST_COMPLETE = 2'd2,
        ST_ERROR    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CRC,
        S_DIV_INIT,
        S_DIV_CHECK,
        S_DIV,
        S_DIV_FIN,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic             start;
        logic             data;
        logic             end_item;
        logic             crc_step;
        logic             div_init;
        logic             div_check;
        logic             div_step;
        logic [IDX_W-1:0] div_idx;
        logic             div_fin;
        logic             out_load;
    } cmd_t;

    typedef struct packed {
        logic take_byte;
    } sts_t;

endpackage

// File: hdl/crchk_ctrl.sv
// Controller FSM of the chunked receive checker: input/output handshakes,
// CRC and divider sequencing. Uses crchk_pkg; drives crchk_dp through cmd_t.
module crchk_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          action,
    input  logic                last_in_chunk,
    output logic                out_valid,
    input  logic                out_stall,
    input  crchk_pkg::sts_t     sts,
    output crchk_pkg::cmd_t     cmd
);

    crchk_pkg::state_t                state_reg, state_next;
    logic [crchk_pkg::IDX_W-1:0]      cnt_reg, cnt_next;
    logic                             last_reg, last_next;
    logic                             out_valid_reg, out_valid_next;
    logic                             accept;
    logic                             out_free;
    logic                             cnt_done;

    assign in_stall  = (state_reg != crchk_pkg::S_IDLE);
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cnt_done  = (cnt_reg == {crchk_pkg::IDX_W{1'b1}});
    assign out_valid = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            crchk_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (action)
                        crchk_pkg::ACT_START: state_next = crchk_pkg::S_EMIT;
                        crchk_pkg::ACT_END:   state_next = crchk_pkg::S_EMIT;
                        crchk_pkg::ACT_DATA:
                        begin
                            if (sts.take_byte)
                                state_next = crchk_pkg::S_CRC;
                            else if (last_in_chunk)
                                state_next = crchk_pkg::S_DIV_INIT;
                        end
                        default: state_next = crchk_pkg::S_IDLE;
                    endcase
                end
            end
            crchk_pkg::S_CRC:
            begin
                if (cnt_done)
                    state_next = last_reg ? crchk_pkg::S_DIV_INIT : crchk_pkg::S_IDLE;
            end
            crchk_pkg::S_DIV_INIT:  state_next = crchk_pkg::S_DIV_CHECK;
            crchk_pkg::S_DIV_CHECK: state_next = crchk_pkg::S_DIV;
            crchk_pkg::S_DIV:
            begin
                if (cnt_done)
                    state_next = crchk_pkg::S_DIV_FIN;
            end
            crchk_pkg::S_DIV_FIN:   state_next = crchk_pkg::S_EMIT;
            crchk_pkg::S_EMIT:
            begin
                if (out_free)
                    state_next = crchk_pkg::S_IDLE;
            end
            default: state_next = crchk_pkg::S_IDLE;
        endcase
    end

    // outputs and counters
    always_comb
    begin
        cmd            = '0;
        cmd.start      = accept && (action == crchk_pkg::ACT_START);
        cmd.data       = accept && (action == crchk_pkg::ACT_DATA);
        cmd.end_item   = accept && (action == crchk_pkg::ACT_END);
        cmd.crc_step   = (state_reg == crchk_pkg::S_CRC);
        cmd.div_init   = (state_reg == crchk_pkg::S_DIV_INIT);
        cmd.div_check  = (state_reg == crchk_pkg::S_DIV_CHECK);
        cmd.div_step   = (state_reg == crchk_pkg::S_DIV);
        cmd.div_idx    = ~cnt_reg;  // MSB first
        cmd.div_fin    = (state_reg == crchk_pkg::S_DIV_FIN);
        cmd.out_load   = (state_reg == crchk_pkg::S_EMIT) && out_free;

        cnt_next = '0;
        if (state_reg == crchk_pkg::S_CRC || state_reg == crchk_pkg::S_DIV)
            cnt_next = cnt_reg + crchk_pkg::IDX_W'(1);

        last_next = last_reg;
        if (cmd.data)
            last_next = last_in_chunk;

        out_valid_next = cmd.out_load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= crchk_pkg::S_IDLE;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: hdl/crchk_dp.sv
// Datapath of the chunked receive checker: transfer state, bit-serial CRC-32,
// restoring progress divider and the output register. Uses crchk_pkg.
module crchk_dp #(
    parameter int OFFSET_BITS = crchk_pkg::OFFSET_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  crchk_pkg::cmd_t                       cmd,
    output crchk_pkg::sts_t                       sts,
    input  logic [crchk_pkg::FIELD_W-1:0]         expected_crc,
    input  logic [crchk_pkg::FIELD_W-1:0]         expected_size,
    input  logic [crchk_pkg::FIELD_W-1:0]         chunk_offset,
    input  logic [crchk_pkg::BYTE_W-1:0]          data_byte,
    input  logic                                  first_in_chunk,
    input  logic                                  last_in_chunk,
    output logic                                  ack_present,
    output logic                                  ack_code,
    output logic [1:0]                            status_code,
    output logic [crchk_pkg::PROG_W-1:0]          progress_percent
);

    localparam int FW = crchk_pkg::FIELD_W;
    localparam int DW = crchk_pkg::DIV_W;
    localparam int QW = crchk_pkg::QUO_W;
    localparam int PW = crchk_pkg::PROG_W;

    logic [FW-1:0]          want_crc_reg, want_crc_next;
    logic [FW-1:0]          want_size_reg, want_size_next;
    logic [OFFSET_BITS-1:0] next_offset_reg, next_offset_next;
    logic [FW-1:0]          running_crc_reg, running_crc_next;
    logic                   chunk_taken_reg, chunk_taken_next;
    crchk_pkg::status_t     cur_status_reg, cur_status_next;

    logic [DW-1:0]          rem_reg, rem_next;
    logic [QW-1:0]          quo_reg, quo_next;
    logic                   sat_reg, sat_next;
    logic                   pend_ack_reg, pend_ack_next;
    logic                   pend_code_reg, pend_code_next;
    logic [PW-1:0]          pend_prog_reg, pend_prog_next;

    logic                   ack_present_reg;
    logic                   ack_code_reg;
    logic [1:0]             status_code_reg;
    logic [PW-1:0]          progress_reg;

    logic                   take_byte;
    logic [DW-1:0]          off_ext;
    logic [DW-1:0]          divisor;
    logic [DW-1:0]          size_top;

    // chunk decision is made on the first beat, then held for the rest
    assign take_byte     = first_in_chunk ? (chunk_offset == FW'(next_offset_reg))
                                          : chunk_taken_reg;
    assign sts.take_byte = take_byte;

    assign off_ext  = DW'(next_offset_reg);
    assign divisor  = DW'(want_size_reg) << cmd.div_idx;
    assign size_top = {want_size_reg, {QW{1'b0}}};

    always_comb
    begin
        want_crc_next    = want_crc_reg;
        want_size_next   = want_size_reg;
        next_offset_next = next_offset_reg;
        running_crc_next = running_crc_reg;
        chunk_taken_next = chunk_taken_reg;
        cur_status_next  = cur_status_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        sat_next         = sat_reg;
        pend_ack_next    = pend_ack_reg;
        pend_code_next   = pend_code_reg;
        pend_prog_next   = pend_prog_reg;

        if (cmd.start)
        begin
            want_crc_next    = expected_crc;
            want_size_next   = expected_size;
            next_offset_next = '0;
            running_crc_next = crchk_pkg::CRC_INIT;
            chunk_taken_next = 1'b0;
            cur_status_next  = crchk_pkg::ST_STARTED;
            pend_ack_next    = 1'b1;
            pend_code_next   = 1'b0;
            pend_prog_next   = '0;
        end

        if (cmd.data)
        begin
            chunk_taken_next = take_byte;
            if (take_byte)
            begin
                running_crc_next = running_crc_reg ^ FW'(data_byte);
                next_offset_next = next_offset_reg + OFFSET_BITS'(1);
            end
            if (last_in_chunk)
            begin
                cur_status_next = take_byte ? crchk_pkg::ST_TRANSFER : crchk_pkg::ST_ERROR;
                pend_ack_next   = 1'b1;
                pend_code_next  = !take_byte;
            end
        end

        if (cmd.end_item)
        begin
            cur_status_next = ((~running_crc_reg) == want_crc_reg) ? crchk_pkg::ST_COMPLETE
                                                                   : crchk_pkg::ST_ERROR;
            pend_ack_next   = 1'b0;
            pend_code_next  = 1'b0;
            pend_prog_next  = crchk_pkg::PERCENT_FULL;
        end

        // one polynomial step per cycle, byte already xored in
        if (cmd.crc_step)
            running_crc_next = (running_crc_reg >> 1)
                             ^ (running_crc_reg[0] ? crchk_pkg::CRC_POLY : '0);

        // offset * 100 as shift-add
        if (cmd.div_init)
        begin
            rem_next = (off_ext << 6) + (off_ext << 5) + (off_ext << 2);
            quo_next = '0;
            sat_next = (want_size_reg == '0);
        end

        // quotient of 256 or more: clamp, skip the real value
        if (cmd.div_check)
        begin
            if (rem_reg >= size_top)
                sat_next = 1'b1;
        end

        if (cmd.div_step)
        begin
            if (rem_reg >= divisor)
            begin
                rem_next              = rem_reg - divisor;
                quo_next[cmd.div_idx] = 1'b1;
            end
        end

        if (cmd.div_fin)
        begin
            if (sat_reg || (quo_reg > QW'(crchk_pkg::PERCENT_FULL)))
                pend_prog_next = crchk_pkg::PERCENT_FULL;
            else
                pend_prog_next = quo_reg[PW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            want_crc_reg    <= '0;
            want_size_reg   <= '0;
            next_offset_reg <= '0;
            running_crc_reg <= crchk_pkg::CRC_INIT;
            chunk_taken_reg <= 1'b0;
            cur_status_reg  <= crchk_pkg::ST_STARTED;
        end
        else
        begin
            want_crc_reg    <= want_crc_next;
            want_size_reg   <= want_size_next;
            next_offset_reg <= next_offset_next;
            running_crc_reg <= running_crc_next;
            chunk_taken_reg <= chunk_taken_next;
            cur_status_reg  <= cur_status_next;
        end
    end

    // work and result registers, no reset needed
    always_ff @(posedge clk)
    begin
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        sat_reg       <= sat_next;
        pend_ack_reg  <= pend_ack_next;
        pend_code_reg <= pend_code_next;
        pend_prog_reg <= pend_prog_next;
        if (cmd.out_load)
        begin
            ack_present_reg <= pend_ack_reg;
            ack_code_reg    <= pend_code_reg;
            status_code_reg <= cur_status_reg;
            progress_reg    <= pend_prog_reg;
        end
    end

    assign ack_present      = ack_present_reg;
    assign ack_code         = ack_code_reg;
    assign status_code      = status_code_reg;
    assign progress_percent = progress_reg;

endmodule

// File: hdl/chunked_receive_checker_unit.sv
// Top level of the chunked receive checker: controller plus datapath.
// Depends on crchk_pkg, crchk_ctrl and crchk_dp.
//
// Receive-side checker for a chunked file transfer. One input beat carries a
// start, a data byte or an end. A start loads the announced CRC-32 and byte
// count, clears the offset and answers with an ok ack (status started,
// progress 0). A data byte is taken only if its chunk was accepted: the first
// byte's chunk_offset must equal the running offset, and that decision holds
// for the following bytes of the chunk. A taken byte advances the offset and
// the CRC-32 (reflected 0xEDB88320, init all ones, final inversion). The last
// byte of a chunk gives an ack (ok / sequencing error), the status
// (transferring / error) and the progress floor(offset*100/size), clamped to
// 100 and 100 for size 0. An end beat gives no ack, complete or error from the
// CRC compare, and progress 100. Action 3 is dropped without a result.
// Timing: one beat at a time; in_stall is high while a beat is in work.
// Start and end go through the emit state to the output register. A taken
// data byte is accepted, then gets 8 bit-serial CRC steps. A rejected
// non-last byte needs no more work. Chunk end adds the progress divide
// (product, range check, 8 restoring steps, clamp) before the result is loaded.
// The output register frees the input side: the next beat can be taken while a
// result waits on out_stall, but a new result waits until the old one is taken.
// OFFSET_BITS (16..32) sets the width of the running offset, which wraps.
module chunked_receive_checker_unit #(
    parameter int OFFSET_BITS = crchk_pkg::OFFSET_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [1:0]                            action,
    input  logic [crchk_pkg::FIELD_W-1:0]         expected_crc,
    input  logic [crchk_pkg::FIELD_W-1:0]         expected_size,
    input  logic [crchk_pkg::FIELD_W-1:0]         chunk_offset,
    input  logic [crchk_pkg::BYTE_W-1:0]          data_byte,
    input  logic                                  first_in_chunk,
    input  logic                                  last_in_chunk,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic                                  ack_present,
    output logic                                  ack_code,
    output logic [1:0]                            status_code,
    output logic [crchk_pkg::PROG_W-1:0]          progress_percent
);

    crchk_pkg::cmd_t cmd;
    crchk_pkg::sts_t sts;

    // sequencing: handshakes, CRC step count, divider steps
    crchk_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .last_in_chunk (last_in_chunk),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sts           (sts),
        .cmd           (cmd)
    );

    // transfer state, CRC, progress divider, result register
    crchk_dp #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .expected_crc     (expected_crc),
        .expected_size    (expected_size),
        .chunk_offset     (chunk_offset),
        .data_byte        (data_byte),
        .first_in_chunk   (first_in_chunk),
        .last_in_chunk    (last_in_chunk),
        .ack_present      (ack_present),
        .ack_code         (ack_code),
        .status_code      (status_code),
        .progress_percent (progress_percent)
    );

endmodule
